// ===== src/assert_macros.svh =====
// Assertion helpers for the page controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/i2cpc_pkg.sv =====
`timescale 1ns / 1ps
package i2cpc_pkg;
  localparam int PAGE_BYTES_DEF = 8;
  localparam logic [11:0] DIV_RESET = 12'd199;

  typedef enum logic [1:0] {REQ_TICK = 2'd0, REQ_WRITE = 2'd1, REQ_READ = 2'd2,
    REQ_NONE = 2'd3} req_t;
  typedef enum logic [1:0] {SEL_CMD = 2'd0, SEL_LO = 2'd1, SEL_HI = 2'd2,
    SEL_NONE = 2'd3} sel_t;

  localparam logic [2:0] CODE_START     = 3'd1;
  localparam logic [2:0] CODE_WRITE     = 3'd2;
  localparam logic [2:0] CODE_STOP      = 3'd3;
  localparam logic [2:0] CODE_READ_LAST = 3'd4;
  localparam logic [2:0] CODE_READ      = 3'd5;

  localparam logic [1:0] CFG_DIV     = 2'd0;
  localparam logic [1:0] CFG_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_STRETCH = 2'd2;

  typedef enum logic [2:0] {PH_IDLE, PH_START, PH_STOP, PH_WRITE, PH_READ} phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
    logic        sda_in;
    logic        scl_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
  } out_item_t;

  typedef struct packed {
    logic [11:0] divider;
    logic        enable;
    logic        stretch;
  } cfg_t;
endpackage

// ===== src/i2cpc_if.sv =====
`timescale 1ns / 1ps
interface i2cpc_in_if;
  import i2cpc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cpc_out_if;
  import i2cpc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/i2c_master_page_controller.sv =====
`timescale 1ns / 1ps
// I2C master with an eight-byte page buffer.
// in channel: one transaction is a clock tick, a register write or a register
// read, with the sampled SDA and SCL levels alongside.
// out channel: one transaction per input transaction, carrying the read data,
// the SCL and SDA pull-down controls and the busy flag after that item.
// cfg port: write enable, index and data; 0 divider, 1 enable, 2 stretch.
// Throughput: one transaction per cycle while in_ready is high; the state update
// is a single pass of logic between the state registers, and the result sits
// in one output register with a skid stage so input is taken while a result
// waits.
// Reset: divider 199, enable and stretch on, buffer and status cleared,
// both lines released, no result pending.
// When the receiver stalls, the skid stage holds one result and then in_ready
// drops until the output drains.
module i2c_master_page_controller
  import i2cpc_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  i2cpc_in_if.sink      in_ch,
  i2cpc_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [11:0]   cfg_wdata
);
`include "assert_macros.svh"

  cfg_t      cfg;
  logic      disable_pulse;
  logic      step;
  out_item_t res;
  out_item_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;

  i2cpc_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .cfg, .disable_pulse
  );

  assign in_ch.ready = !skid_valid_r;
  assign step = in_ch.valid && in_ch.ready;

  i2cpc_core #(.PAGE_BYTES(PAGE_BYTES)) u_core (
    .clk, .rst_n, .cfg, .disable_pulse, .step, .item(in_ch.data), .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= skid_valid_r || step;
        skid_valid_r <= 1'b0;
      end else if (step) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (step) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  `ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `ASSERT_NEXT(a_step_gives_out, clk, rst_n, step, out_valid_r)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid_r && !out_ch.ready && skid_valid_r,
               skid_valid_r && $stable(out_r))
endmodule

// ===== src/i2cpc_cfg.sv =====
`timescale 1ns / 1ps
module i2cpc_cfg
  import i2cpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  output cfg_t        cfg,
  output logic        disable_pulse
);
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{divider: DIV_RESET, enable: 1'b1, stretch: 1'b1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIV:     cfg_r.divider <= cfg_wdata;
        CFG_ENABLE:  cfg_r.enable <= cfg_wdata[0];
        CFG_STRETCH: cfg_r.stretch <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
  assign disable_pulse = cfg_we && (cfg_index == CFG_ENABLE) && !cfg_wdata[0];
endmodule

// ===== src/i2cpc_core.sv =====
`timescale 1ns / 1ps
module i2cpc_core
  import i2cpc_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      disable_pulse,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t res
);
  localparam logic [2:0] LEN_MAX = 3'(PAGE_BYTES - 1);

  logic [7:0]  page_r [8];
  logic [7:0]  page_nxt [8];
  logic [7:0]  ack_r, ack_nxt;
  logic [2:0]  code_r, code_nxt, len_r, len_nxt;
  logic        busy_r, busy_nxt;
  logic [11:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  phase_t      ph_r, ph_nxt;
  logic [1:0]  line_r, line_nxt;

  logic [11:0] d, low_len;
  logic        sda_low, last_rd;
  logic [2:0]  code, len;
  logic [7:0]  shifted;
  logic [31:0] rd;

  always_comb begin
    d = (cfg.divider == 12'd0) ? 12'd1 : cfg.divider;
    low_len = {1'b0, d[11:1]} + 12'd1;
    last_rd = (code_r == CODE_READ_LAST) && (byte_r >= len_r);
    sda_low = 1'b0;
    case (ph_r)
      PH_STOP:  sda_low = 1'b1;
      PH_WRITE: sda_low = !bit_r[3] && !shift_r[3'd7 - bit_r[2:0]];
      PH_READ:  sda_low = bit_r[3] && !last_rd;
      default:  sda_low = 1'b0;
    endcase
    code = item.write_data[6:4];
    len = (item.write_data[10:8] > LEN_MAX) ? LEN_MAX : item.write_data[10:8];
    shifted = {shift_r[6:0], item.sda_in};
  end

  always_comb begin
    page_nxt = page_r;
    ack_nxt = ack_r;
    code_nxt = code_r;
    len_nxt = len_r;
    busy_nxt = busy_r;
    tick_nxt = tick_r;
    bit_nxt = bit_r;
    byte_nxt = byte_r;
    shift_nxt = shift_r;
    ph_nxt = ph_r;
    line_nxt = line_r;
    rd = '0;
    if (step) begin
      case (req_t'(item.req_type))
        REQ_TICK: begin
          if (cfg.enable && ph_r != PH_IDLE) begin
            if (tick_r < low_len) begin
              line_nxt = {sda_low, 1'b1};
              tick_nxt = tick_r + 12'd1;
            end else begin
              line_nxt = {sda_low, 1'b0};
              if (!(cfg.stretch && !item.scl_in)) begin
                if (tick_r < d) begin
                  tick_nxt = tick_r + 12'd1;
                end else begin
                  tick_nxt = '0;
                  case (ph_r)
                    PH_START, PH_STOP: begin
                      line_nxt = {ph_r == PH_START, 1'b0};
                      busy_nxt = 1'b0;
                      ph_nxt = PH_IDLE;
                      bit_nxt = '0;
                    end
                    default: begin
                      if (!bit_r[3]) begin
                        if (ph_r == PH_READ) begin
                          shift_nxt = shifted;
                          if (bit_r == 4'd7 && 32'(byte_r) < 32'(PAGE_BYTES))
                            page_nxt[byte_r] = shifted;
                        end
                        bit_nxt = bit_r + 4'd1;
                      end else begin
                        if (ph_r == PH_WRITE && !item.sda_in)
                          ack_nxt[byte_r] = 1'b1;
                        if (byte_r >= len_r) begin
                          busy_nxt = 1'b0;
                          ph_nxt = PH_IDLE;
                          bit_nxt = '0;
                        end else begin
                          byte_nxt = byte_r + 3'd1;
                          bit_nxt = '0;
                          shift_nxt = (ph_r == PH_WRITE) ? page_r[byte_r + 3'd1] : 8'd0;
                        end
                      end
                    end
                  endcase
                end
              end
            end
          end
        end
        REQ_WRITE: begin
          case (sel_t'(item.reg_select))
            SEL_CMD: begin
              if (cfg.enable && !busy_r && item.write_data[0] &&
                  code >= CODE_START && code <= CODE_READ) begin
                code_nxt = code;
                len_nxt = len;
                ack_nxt = '0;
                busy_nxt = 1'b1;
                tick_nxt = '0;
                bit_nxt = '0;
                byte_nxt = '0;
                shift_nxt = '0;
                case (code)
                  CODE_START: ph_nxt = PH_START;
                  CODE_STOP:  ph_nxt = PH_STOP;
                  CODE_WRITE: begin
                    ph_nxt = PH_WRITE;
                    shift_nxt = page_r[0];
                  end
                  default:    ph_nxt = PH_READ;
                endcase
              end
            end
            SEL_LO, SEL_HI: begin
              if (!busy_r) begin
                for (int k = 0; k < 4; k++) begin
                  if ((k + (item.reg_select == SEL_HI ? 4 : 0)) < PAGE_BYTES)
                    page_nxt[3'(k) + (item.reg_select == SEL_HI ? 3'd4 : 3'd0)] =
                      item.write_data[8*k +: 8];
                end
              end
            end
            default: ;
          endcase
        end
        REQ_READ: begin
          case (sel_t'(item.reg_select))
            SEL_CMD: rd = {8'd0, ack_r, 5'd0, len_r, 1'b0, code_r, 3'd0, busy_r};
            SEL_LO, SEL_HI: begin
              for (int k = 0; k < 4; k++) begin
                if ((k + (item.reg_select == SEL_HI ? 4 : 0)) < PAGE_BYTES)
                  rd[8*k +: 8] = page_r[3'(k) + (item.reg_select == SEL_HI ? 3'd4 : 3'd0)];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (disable_pulse) begin
      busy_nxt = 1'b0;
      ph_nxt = PH_IDLE;
      tick_nxt = '0;
      bit_nxt = '0;
      line_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) page_r[k] <= '0;
      ack_r <= '0;
      code_r <= '0;
      len_r <= '0;
      busy_r <= 1'b0;
      tick_r <= '0;
      bit_r <= '0;
      byte_r <= '0;
      shift_r <= '0;
      ph_r <= PH_IDLE;
      line_r <= '0;
    end else begin
      page_r <= page_nxt;
      ack_r <= ack_nxt;
      code_r <= code_nxt;
      len_r <= len_nxt;
      busy_r <= busy_nxt;
      tick_r <= tick_nxt;
      bit_r <= bit_nxt;
      byte_r <= byte_nxt;
      shift_r <= shift_nxt;
      ph_r <= ph_nxt;
      line_r <= line_nxt;
    end
  end

  always_comb begin
    res.read_data = rd;
    res.scl_drive_low = cfg.enable && line_nxt[0];
    res.sda_drive_low = cfg.enable && line_nxt[1];
    res.busy_res = busy_nxt;
  end
endmodule
